### rtl/psn_pkg.sv
// Shared types and result codes for the point-to-segment nearest point block.
package psn_pkg;

    localparam logic [1:0] WHERE_START = 2'd0;
    localparam logic [1:0] WHERE_END   = 2'd1;
    localparam logic [1:0] WHERE_FOOT  = 2'd2;

    typedef struct packed {
        logic [1:0] code;
        logic       neg_x;
        logic       neg_y;
    } t_ctl;

endpackage

### rtl/psn_prep.sv
// Front pipeline: differences, products, sums, classification and the squared cross term.
module psn_prep import psn_pkg::*; #(
    parameter int CB = 16,
    localparam int DW = CB + 1,
    localparam int PW = 2 * DW,
    localparam int LW = 2 * CB + 1,
    localparam int TW = 2 * CB + 2,
    localparam int CW = 2 * CB + 1,
    localparam int HL = CB + 1,
    localparam int HH = CW - HL,
    localparam int VW = 4 * CB + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CB-1:0] i_sx,
    input  logic signed [CB-1:0] i_sy,
    input  logic signed [CB-1:0] i_ex,
    input  logic signed [CB-1:0] i_ey,
    input  logic signed [CB-1:0] i_qx,
    input  logic signed [CB-1:0] i_qy,
    output logic                 o_valid,
    output t_ctl                 o_ctl,
    output logic signed [CB-1:0] o_sx,
    output logic signed [CB-1:0] o_sy,
    output logic signed [CB-1:0] o_ex,
    output logic signed [CB-1:0] o_ey,
    output logic [DW-1:0]        o_magx,
    output logic [DW-1:0]        o_magy,
    output logic [LW-1:0]        o_num,
    output logic [LW-1:0]        o_den,
    output logic [VW-1:0]        o_v,
    output logic [LW-1:0]        o_scale
);

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [CB-1:0] r1_sx, r1_sy, r1_ex, r1_ey;
    logic signed [CB-1:0] r2_sx, r2_sy, r2_ex, r2_ey;
    logic signed [CB-1:0] r3_sx, r3_sy, r3_ex, r3_ey;
    logic signed [CB-1:0] r4_sx, r4_sy, r4_ex, r4_ey;
    logic signed [CB-1:0] r5_sx, r5_sy, r5_ex, r5_ey;

    logic signed [DW-1:0] r1_dx, r1_dy, r1_rx, r1_ry, r1_ax, r1_ay;
    logic signed [DW-1:0] r2_dx, r2_dy;
    logic signed [PW-1:0] r2_dxx, r2_dyy, r2_dxr, r2_dyr, r2_c1, r2_c2;
    logic signed [PW-1:0] r2_rxx, r2_ryy, r2_axx, r2_ayy;

    logic [LW-1:0]        r3_len, r3_ps, r3_pe;
    logic signed [TW-1:0] r3_dot;
    logic [CW-1:0]        r3_crm;
    logic [DW-1:0]        r3_magx, r3_magy;
    logic                 r3_negx, r3_negy;
    logic signed [TW-1:0] n3_cr;

    t_ctl                 r4_ctl, r5_ctl;
    logic [1:0]           n4_code;
    logic [LW-1:0]        r4_len, r4_num, r4_pend;
    logic [DW-1:0]        r4_magx, r4_magy, r5_magx, r5_magy;
    logic [2*HL-1:0]      r4_pll;
    logic [HH+HL-1:0]     r4_phl;
    logic [2*HH-1:0]      r4_phh;
    logic [LW-1:0]        r5_num, r5_den, r5_scale;
    logic [VW-1:0]        r5_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sx <= i_sx;
            r1_sy <= i_sy;
            r1_ex <= i_ex;
            r1_ey <= i_ey;
            r2_sx <= r1_sx;
            r2_sy <= r1_sy;
            r2_ex <= r1_ex;
            r2_ey <= r1_ey;
            r3_sx <= r2_sx;
            r3_sy <= r2_sy;
            r3_ex <= r2_ex;
            r3_ey <= r2_ey;
            r4_sx <= r3_sx;
            r4_sy <= r3_sy;
            r4_ex <= r3_ex;
            r4_ey <= r3_ey;
            r5_sx <= r4_sx;
            r5_sy <= r4_sy;
            r5_ex <= r4_ex;
            r5_ey <= r4_ey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= DW'(i_ex) - DW'(i_sx);
            r1_dy <= DW'(i_ey) - DW'(i_sy);
            r1_rx <= DW'(i_qx) - DW'(i_sx);
            r1_ry <= DW'(i_qy) - DW'(i_sy);
            r1_ax <= DW'(i_qx) - DW'(i_ex);
            r1_ay <= DW'(i_qy) - DW'(i_ey);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_dxx <= r1_dx * r1_dx;
            r2_dyy <= r1_dy * r1_dy;
            r2_dxr <= r1_dx * r1_rx;
            r2_dyr <= r1_dy * r1_ry;
            r2_c1  <= r1_dx * r1_ry;
            r2_c2  <= r1_dy * r1_rx;
            r2_rxx <= r1_rx * r1_rx;
            r2_ryy <= r1_ry * r1_ry;
            r2_axx <= r1_ax * r1_ax;
            r2_ayy <= r1_ay * r1_ay;
        end
    end

    assign n3_cr = TW'(r2_c1) - TW'(r2_c2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_len  <= LW'(r2_dxx) + LW'(r2_dyy);
            r3_ps   <= LW'(r2_rxx) + LW'(r2_ryy);
            r3_pe   <= LW'(r2_axx) + LW'(r2_ayy);
            r3_dot  <= TW'(r2_dxr) + TW'(r2_dyr);
            r3_crm  <= n3_cr[TW-1] ? CW'(-n3_cr) : CW'(n3_cr);
            r3_magx <= r2_dx[DW-1] ? -r2_dx : r2_dx;
            r3_magy <= r2_dy[DW-1] ? -r2_dy : r2_dy;
            r3_negx <= r2_dx[DW-1];
            r3_negy <= r2_dy[DW-1];
        end
    end

    always_comb begin
        if (r3_len == '0 || r3_dot[TW-1] || r3_dot == '0) begin
            n4_code = WHERE_START;
        end else if (r3_dot >= $signed({1'b0, r3_len})) begin
            n4_code = WHERE_END;
        end else begin
            n4_code = WHERE_FOOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ctl.code  <= n4_code;
            r4_ctl.neg_x <= r3_negx;
            r4_ctl.neg_y <= r3_negy;
            r4_len       <= r3_len;
            r4_num       <= LW'(r3_dot);
            r4_pend      <= (n4_code == WHERE_END) ? r3_pe : r3_ps;
            r4_magx      <= r3_magx;
            r4_magy      <= r3_magy;
            r4_pll       <= r3_crm[HL-1:0] * r3_crm[HL-1:0];
            r4_phl       <= r3_crm[CW-1:HL] * r3_crm[HL-1:0];
            r4_phh       <= r3_crm[CW-1:HL] * r3_crm[CW-1:HL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ctl  <= r4_ctl;
            r5_magx <= r4_magx;
            r5_magy <= r4_magy;
            r5_num  <= r4_num;
            r5_den  <= r4_len;
            if (r4_ctl.code == WHERE_FOOT) begin
                r5_sq    <= (VW'(r4_phh) << (2 * HL)) + (VW'(r4_phl) << (HL + 1))
                            + VW'(r4_pll);
                r5_scale <= r4_len;
            end else begin
                r5_sq    <= VW'(r4_pend);
                r5_scale <= LW'(1);
            end
        end
    end

    assign o_valid = r5_v;
    assign o_ctl   = r5_ctl;
    assign o_sx    = r5_sx;
    assign o_sy    = r5_sy;
    assign o_ex    = r5_ex;
    assign o_ey    = r5_ey;
    assign o_magx  = r5_magx;
    assign o_magy  = r5_magy;
    assign o_num   = r5_num;
    assign o_den   = r5_den;
    assign o_v     = r5_sq;
    assign o_scale = r5_scale;

endmodule

### rtl/psn_div.sv
// Pipelined scaled divider: floor(mag * num / den) one digit per stage, plus round bit.
module psn_div import psn_pkg::*; #(
    parameter int CB = 16,
    localparam int MW = CB + 1,
    localparam int LW = 2 * CB + 1,
    localparam int RW = LW + 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [MW-1:0] i_mag,
    input  logic [LW-1:0] i_num,
    input  logic [LW-1:0] i_den,
    output logic [MW-1:0] o_q,
    output logic          o_up
);

    logic [MW-1:0] r_mag [MW-1];
    logic [LW-1:0] r_num [MW-1];
    logic [MW-1:0] r_q   [MW];
    logic [LW-1:0] r_den [MW];
    logic [LW-1:0] r_rem [MW];

    for (genvar g = 0; g < MW; g++) begin : g_stage
        logic [MW-1:0] mag_in, q_in;
        logic [LW-1:0] num_in, den_in, rem_in;
        logic [RW-1:0] acc, two_den, rem_w;
        logic [1:0]    dig;

        if (g == 0) begin : g_first
            assign mag_in = i_mag;
            assign num_in = i_num;
            assign den_in = i_den;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign mag_in = r_mag[g-1];
            assign num_in = r_num[g-1];
            assign den_in = r_den[g-1];
            assign rem_in = r_rem[g-1];
            assign q_in   = r_q[g-1];
        end

        always_comb begin
            acc     = RW'({rem_in, 1'b0}) + (mag_in[MW-1-g] ? RW'(num_in) : '0);
            two_den = RW'({den_in, 1'b0});
            if (acc >= two_den) begin
                dig   = 2'd2;
                rem_w = acc - two_den;
            end else if (acc >= RW'(den_in)) begin
                dig   = 2'd1;
                rem_w = acc - RW'(den_in);
            end else begin
                dig   = 2'd0;
                rem_w = acc;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]   <= MW'({q_in, 1'b0} + (MW + 1)'(dig));
                r_rem[g] <= LW'(rem_w);
                r_den[g] <= den_in;
            end
        end

        if (g < MW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_mag[g] <= mag_in;
                    r_num[g] <= num_in;
                end
            end
        end
    end

    assign o_q  = r_q[MW-1];
    assign o_up = (LW + 1)'({r_rem[MW-1], 1'b0}) >= (LW + 1)'(r_den[MW-1]);

endmodule

### rtl/psn_root.sv
// Pipelined scaled square root: largest k with k*k*scale <= v, one bit per stage.
module psn_root import psn_pkg::*; #(
    parameter int CB = 16,
    localparam int KW = CB + 1,
    localparam int LW = 2 * CB + 1,
    localparam int VW = 4 * CB + 2,
    localparam int SW = 4 * CB + 4,
    localparam int MKW = 3 * CB + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [VW-1:0] i_v,
    input  logic [LW-1:0] i_scale,
    output logic          o_valid,
    output logic [KW-1:0] o_k
);

    logic           r_vld [KW];
    logic [KW-1:0]  r_k   [KW];
    logic [VW-1:0]  r_s   [KW-1];
    logic [MKW-1:0] r_m   [KW-1];
    logic [VW-1:0]  r_v   [KW-1];
    logic [LW-1:0]  r_sc  [KW-1];

    for (genvar g = 0; g < KW; g++) begin : g_stage
        localparam int SH = KW - 1 - g;
        logic           vld_in, ok;
        logic [KW-1:0]  k_in;
        logic [VW-1:0]  s_in, v_in;
        logic [MKW-1:0] m_in;
        logic [LW-1:0]  sc_in;
        logic [SW-1:0]  cand;

        if (g == 0) begin : g_first
            assign vld_in = i_valid;
            assign k_in   = '0;
            assign s_in   = '0;
            assign m_in   = '0;
            assign v_in   = i_v;
            assign sc_in  = i_scale;
        end else begin : g_next
            assign vld_in = r_vld[g-1];
            assign k_in   = r_k[g-1];
            assign s_in   = r_s[g-1];
            assign m_in   = r_m[g-1];
            assign v_in   = r_v[g-1];
            assign sc_in  = r_sc[g-1];
        end

        assign cand = SW'(s_in) + (SW'(m_in) << (SH + 1)) + (SW'(sc_in) << (2 * SH));
        assign ok   = cand <= SW'(v_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_k[g] <= ok ? (k_in | (KW'(1) << SH)) : k_in;
            end
        end

        if (g < KW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s[g]  <= ok ? VW'(cand) : s_in;
                    r_m[g]  <= ok ? (m_in + (MKW'(sc_in) << SH)) : m_in;
                    r_v[g]  <= v_in;
                    r_sc[g] <= sc_in;
                end
            end
        end
    end

    assign o_valid = r_vld[KW-1];
    assign o_k     = r_k[KW-1];

endmodule

### rtl/psn_out.sv
// Result assembly, rounding of the foot point, and output register with skid stage.
module psn_out import psn_pkg::*; #(
    parameter int CB = 16,
    localparam int KW = CB + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_ctl                 i_ctl,
    input  logic signed [CB-1:0] i_sx,
    input  logic signed [CB-1:0] i_sy,
    input  logic signed [CB-1:0] i_ex,
    input  logic signed [CB-1:0] i_ey,
    input  logic [KW-1:0]        i_qx,
    input  logic [KW-1:0]        i_qy,
    input  logic                 i_upx,
    input  logic                 i_upy,
    input  logic [KW-1:0]        i_k,
    input  logic                 i_stall,
    output logic                 o_en,
    output logic                 o_valid,
    output logic [1:0]           o_where_code,
    output logic signed [CB-1:0] o_near_x,
    output logic signed [CB-1:0] o_near_y,
    output logic [KW-1:0]        o_distance
);

    logic signed [KW-1:0] ox, oy, sxe, sye, fx, fy;
    logic signed [CB-1:0] nx, ny;

    logic                 r_ov, r_sk_full;
    logic [1:0]           r_code, r_sk_code;
    logic signed [CB-1:0] r_nx, r_ny, r_sk_nx, r_sk_ny;
    logic [KW-1:0]        r_dist, r_sk_dist;

    assign ox  = $signed(i_qx + KW'(i_upx));
    assign oy  = $signed(i_qy + KW'(i_upy));
    assign sxe = KW'(i_sx);
    assign sye = KW'(i_sy);
    assign fx  = i_ctl.neg_x ? sxe - ox : sxe + ox;
    assign fy  = i_ctl.neg_y ? sye - oy : sye + oy;

    always_comb begin
        case (i_ctl.code)
            WHERE_START: begin
                nx = i_sx;
                ny = i_sy;
            end
            WHERE_END: begin
                nx = i_ex;
                ny = i_ey;
            end
            default: begin
                nx = CB'(fx);
                ny = CB'(fy);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov      <= 1'b0;
            r_sk_full <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            if (r_sk_full) begin
                r_ov      <= 1'b1;
                r_sk_full <= 1'b0;
            end else begin
                r_ov <= i_valid;
            end
        end else if (i_valid && !r_sk_full) begin
            r_sk_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            if (r_sk_full) begin
                r_code <= r_sk_code;
                r_nx   <= r_sk_nx;
                r_ny   <= r_sk_ny;
                r_dist <= r_sk_dist;
            end else begin
                r_code <= i_ctl.code;
                r_nx   <= nx;
                r_ny   <= ny;
                r_dist <= i_k;
            end
        end else if (!r_sk_full) begin
            r_sk_code <= i_ctl.code;
            r_sk_nx   <= nx;
            r_sk_ny   <= ny;
            r_sk_dist <= i_k;
        end
    end

    assign o_en         = !r_sk_full;
    assign o_valid      = r_ov;
    assign o_where_code = r_code;
    assign o_near_x     = r_nx;
    assign o_near_y     = r_ny;
    assign o_distance   = r_dist;

endmodule

### rtl/point_segment_nearest.sv
// Top level of the point-to-segment nearest point and distance pipeline.
//
// Input channel: i_valid/o_stall carry one word per cycle holding the segment
// start, the segment end and the query point as signed coordinates. A word is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid/i_stall carry one result word per input word, in
// order: where the nearest point lies (start, end or interior foot), its
// coordinates and the distance to it, rounded down.
// The pipeline has five front stages, COORD_BITS + 1 stages of the divider
// and square root lanes, which run side by side, and the output register.
// Throughput is one word per cycle while o_stall is low.
// When the receiver stalls, the result waits in the output register and the
// next one lands in a skid register; only when the skid register is full does
// o_stall rise and the whole pipeline hold. No word is lost or repeated.
// Reset clears all valid bits and the skid state; the block takes words as
// soon as reset is released.
module point_segment_nearest import psn_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_where_code,
    output logic signed [COORD_BITS-1:0] o_near_x,
    output logic signed [COORD_BITS-1:0] o_near_y,
    output logic [COORD_BITS:0]          o_distance
);

    localparam int CB = COORD_BITS;
    localparam int KW = CB + 1;
    localparam int LW = 2 * CB + 1;
    localparam int VW = 4 * CB + 2;

    logic                 en;
    logic                 p_valid;
    t_ctl                 p_ctl;
    logic signed [CB-1:0] p_sx, p_sy, p_ex, p_ey;
    logic [KW-1:0]        p_magx, p_magy;
    logic [LW-1:0]        p_num, p_den, p_scale;
    logic [VW-1:0]        p_v;

    logic                 rt_valid;
    logic [KW-1:0]        rt_k, qx, qy;
    logic                 upx, upy;

    t_ctl                 r_sb_ctl [KW];
    logic signed [CB-1:0] r_sb_sx [KW];
    logic signed [CB-1:0] r_sb_sy [KW];
    logic signed [CB-1:0] r_sb_ex [KW];
    logic signed [CB-1:0] r_sb_ey [KW];

    psn_prep #(.CB(CB)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_sx    (i_start_x),
        .i_sy    (i_start_y),
        .i_ex    (i_end_x),
        .i_ey    (i_end_y),
        .i_qx    (i_query_x),
        .i_qy    (i_query_y),
        .o_valid (p_valid),
        .o_ctl   (p_ctl),
        .o_sx    (p_sx),
        .o_sy    (p_sy),
        .o_ex    (p_ex),
        .o_ey    (p_ey),
        .o_magx  (p_magx),
        .o_magy  (p_magy),
        .o_num   (p_num),
        .o_den   (p_den),
        .o_v     (p_v),
        .o_scale (p_scale)
    );

    psn_root #(.CB(CB)) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_v     (p_v),
        .i_scale (p_scale),
        .o_valid (rt_valid),
        .o_k     (rt_k)
    );

    psn_div #(.CB(CB)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (p_magx),
        .i_num (p_num),
        .i_den (p_den),
        .o_q   (qx),
        .o_up  (upx)
    );

    psn_div #(.CB(CB)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (p_magy),
        .i_num (p_num),
        .i_den (p_den),
        .o_q   (qy),
        .o_up  (upy)
    );

    for (genvar g = 0; g < KW; g++) begin : g_side
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sb_ctl[g] <= p_ctl;
                    r_sb_sx[g]  <= p_sx;
                    r_sb_sy[g]  <= p_sy;
                    r_sb_ex[g]  <= p_ex;
                    r_sb_ey[g]  <= p_ey;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sb_ctl[g] <= r_sb_ctl[g-1];
                    r_sb_sx[g]  <= r_sb_sx[g-1];
                    r_sb_sy[g]  <= r_sb_sy[g-1];
                    r_sb_ex[g]  <= r_sb_ex[g-1];
                    r_sb_ey[g]  <= r_sb_ey[g-1];
                end
            end
        end
    end

    psn_out #(.CB(CB)) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (rt_valid),
        .i_ctl        (r_sb_ctl[KW-1]),
        .i_sx         (r_sb_sx[KW-1]),
        .i_sy         (r_sb_sy[KW-1]),
        .i_ex         (r_sb_ex[KW-1]),
        .i_ey         (r_sb_ey[KW-1]),
        .i_qx         (qx),
        .i_qy         (qy),
        .i_upx        (upx),
        .i_upy        (upy),
        .i_k          (rt_k),
        .i_stall      (i_stall),
        .o_en         (en),
        .o_valid      (o_valid),
        .o_where_code (o_where_code),
        .o_near_x     (o_near_x),
        .o_near_y     (o_near_y),
        .o_distance   (o_distance)
    );

    assign o_stall = !en;

endmodule

### rtl/psn_checker.sv
// Port-level checker for the nearest point pipeline and its bind to the top level.
module psn_checker import psn_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [1:0]                   o_where_code,
    input logic signed [COORD_BITS-1:0] o_near_x,
    input logic signed [COORD_BITS-1:0] o_near_y,
    input logic [COORD_BITS:0]          o_distance
);

    // Reset empties both the output register and the skid register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall not cleared by reset");

    // A full skid register implies a word is waiting in the output register.
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word pending");

    // The input side stalls only after the receiver held back a waiting word.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall rose without an output stall");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_where_code) && $stable(o_near_x)
            && $stable(o_near_y) && $stable(o_distance))
        else $error("stalled output word changed");

endmodule

bind point_segment_nearest psn_checker #(.COORD_BITS(COORD_BITS)) u_psn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_where_code (o_where_code),
    .o_near_x     (o_near_x),
    .o_near_y     (o_near_y),
    .o_distance   (o_distance)
);
